// ===== rtl/binary_to_decimal_ascii_assert.svh =====
// Assertion macros shared by the binary to decimal ASCII converter modules.
`ifndef BINARY_TO_DECIMAL_ASCII_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BDC_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bdc_pkg.sv =====
// Package with the shared types and constants of the binary to decimal ASCII converter.
package bdc_pkg;

    localparam int VALUE_W        = 17;
    localparam int DIGIT_CHAR_W   = 6;
    localparam int DIGIT_W        = 4;
    localparam int EXP_W          = 4;
    localparam int POW_ENTRIES    = 11;
    localparam int NUM_DIGITS_DEF = 5;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = 1;
    localparam int QCNT_W         = 2;

    localparam logic [DIGIT_CHAR_W-1:0] ASCII_ZERO = 6'd48;
    localparam logic [DIGIT_W-1:0]      DIGIT_MAX  = 4'd9;

    typedef logic [VALUE_W:0] pow_t;

    // Powers of ten, clamped to 2**VALUE_W so that larger ones never subtract.
    localparam pow_t POW10_CLAMP [POW_ENTRIES] = '{
        18'd1, 18'd10, 18'd100, 18'd1000, 18'd10000, 18'd100000,
        18'd131072, 18'd131072, 18'd131072, 18'd131072, 18'd131072
    };

    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] value;
    } bdc_item_t;

endpackage

// ===== rtl/bdc_front.sv =====
// Front end: accepts requests, saturates the value and holds it in a short queue.
module bdc_front #(
    parameter int NUM_DIGITS = bdc_pkg::NUM_DIGITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [bdc_pkg::VALUE_W-1:0] value,
    output bdc_pkg::bdc_item_t          head,
    input  logic                        pop
);
    import bdc_pkg::*;

    localparam logic [VALUE_W-1:0] SAT_LIMIT = VALUE_W'(POW10_CLAMP[NUM_DIGITS] - 18'd1);

    logic [VALUE_W-1:0] slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic [VALUE_W-1:0] value_sat;
    logic               push;
    logic               pop_ok;

    assign in_ready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push      = in_valid && in_ready;
    assign pop_ok    = pop && (count_reg != '0);
    assign value_sat = (value > SAT_LIMIT) ? SAT_LIMIT : value;

    assign head.valid = (count_reg != '0);
    assign head.value = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop_ok ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= value_sat;
        end
    end

`include "binary_to_decimal_ascii_assert.svh"

    `BDC_ASSERT_IMPLY(a_count_bound, 1'b1, count_reg <= QCNT_W'(QUEUE_DEPTH), "Queue overfilled.")
    `BDC_ASSERT_IMPLY(a_pop_nonempty, pop, count_reg != '0, "Pop from an empty queue.")
    `BDC_ASSERT_IMPLY(a_head_sat, head.valid, head.value <= SAT_LIMIT, "Queued value not saturated.")

endmodule

// ===== rtl/bdc_back.sv =====
// Back end: converts one queued value into ASCII digits by repeated subtraction.
module bdc_back #(
    parameter int NUM_DIGITS = bdc_pkg::NUM_DIGITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  bdc_pkg::bdc_item_t               head,
    output logic                             pop,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [bdc_pkg::DIGIT_CHAR_W-1:0] digit_char,
    output logic                             last_digit
);
    import bdc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t                  state_reg, state_next;
    logic [VALUE_W-1:0]      rem_reg, rem_next;
    logic [EXP_W-1:0]        exp_reg, exp_next;
    logic [DIGIT_W-1:0]      digit_reg, digit_next;
    logic                    nz_reg, nz_next;
    logic                    out_valid_reg, out_valid_next;
    logic [DIGIT_CHAR_W-1:0] digit_char_reg;
    logic                    last_digit_reg;
    pow_t                    pow;
    logic                    can_sub;
    logic                    last_col;
    logic                    emit;
    logic                    out_free;
    logic                    load;

    assign pow      = POW10_CLAMP[exp_reg];
    assign can_sub  = ({1'b0, rem_reg} >= pow) && (digit_reg < DIGIT_MAX);
    assign last_col = (exp_reg == '0);
    assign emit     = nz_reg || (digit_reg != '0) || last_col;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        exp_next   = exp_reg;
        digit_next = digit_reg;
        nz_next    = nz_reg;
        pop        = 1'b0;
        load       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop        = 1'b1;
                    rem_next   = head.value;
                    exp_next   = EXP_W'(NUM_DIGITS - 1);
                    digit_next = '0;
                    nz_next    = 1'b0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (can_sub)
                begin
                    rem_next   = rem_reg - pow[VALUE_W-1:0];
                    digit_next = digit_reg + 1'b1;
                end
                else if (!emit || out_free)
                begin
                    load       = emit;
                    nz_next    = nz_reg || (digit_reg != '0);
                    digit_next = '0;
                    if (last_col)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        exp_next = exp_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rem_reg       <= '0;
            exp_reg       <= '0;
            digit_reg     <= '0;
            nz_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rem_reg       <= rem_next;
            exp_reg       <= exp_next;
            digit_reg     <= digit_next;
            nz_reg        <= nz_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            digit_char_reg <= ASCII_ZERO + {2'b00, digit_reg};
            last_digit_reg <= last_col;
        end
    end

    assign out_valid  = out_valid_reg;
    assign digit_char = digit_char_reg;
    assign last_digit = last_digit_reg;

`include "binary_to_decimal_ascii_assert.svh"

    `BDC_ASSERT_IMPLY(a_digit_range, 1'b1, digit_reg <= DIGIT_MAX, "Digit count above nine.")
    `BDC_ASSERT_IMPLY(a_pop_idle, pop, state_reg == ST_IDLE, "Queue popped while converting.")
    `BDC_ASSERT_IMPLY(a_idle_clean, state_reg == ST_IDLE, digit_reg == '0, "Idle with a partial digit.")
    `BDC_ASSERT_NEXT(a_load_valid, load, out_valid_reg, "Loaded digit not presented.")

endmodule

// ===== rtl/binary_to_decimal_ascii.sv =====
// Top level of the binary to decimal ASCII converter.
// Each request carries an unsigned value; values above 10**NUM_DIGITS - 1 saturate to it.
// The block returns the value's decimal ASCII digits, most significant first, with leading
// zeros dropped, a zero value printed as a single '0', and last_digit high on the final digit.
// A two-entry queue in the front takes requests while the back converts. The back uses one
// subtractor: an item starts when the idle back pops it from the queue; each column then takes
// one subtraction per unit of the digit's value and a step that emits the digit and moves on,
// and a column with a digit to emit waits there while out_ready holds the previous digit back.
module binary_to_decimal_ascii #(
    parameter int NUM_DIGITS = bdc_pkg::NUM_DIGITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [bdc_pkg::VALUE_W-1:0]      value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [bdc_pkg::DIGIT_CHAR_W-1:0] digit_char,
    output logic                             last_digit
);
    import bdc_pkg::*;

    bdc_item_t head;
    logic      pop;

    bdc_front #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .value    (value),
        .head     (head),
        .pop      (pop)
    );

    bdc_back #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .digit_char (digit_char),
        .last_digit (last_digit)
    );

endmodule
